[hw/rtl/per_source_pin_lockout_table_core_macros.svh]
// Assertion macros for the per-source PIN lockout table core.
// Included by the top level; no other dependencies.
`ifndef PER_SOURCE_PIN_LOCKOUT_TABLE_CORE_MACROS_SVH
`define PER_SOURCE_PIN_LOCKOUT_TABLE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PSLT_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pslt: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define PSLT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pslt: next-cycle check failed");

`endif

[hw/rtl/pslt_pkg.sv]
// Package for the per-source PIN lockout table: widths, codes, table row and config types.
// No dependencies.
package pslt_pkg;

    // field widths
    localparam int ADDR_W     = 32;
    localparam int TIME_W     = 48;
    localparam int PIN_W      = 20;
    localparam int CNT_W      = 4;
    localparam int BASE_W     = 30;
    localparam int OUTC_W     = 2;
    localparam int SLOT_W     = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // lock length: base shifted by at most 15
    localparam int LEN_W = BASE_W + (1 << CNT_W) - 1;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [CNT_W-1:0]  MISS_MAX = '1;

    // register reset values
    localparam logic [PIN_W-1:0]  PIN_RST        = '0;
    localparam logic [CNT_W-1:0]  FAIL_LIMIT_RST = 4'd5;
    localparam logic [BASE_W-1:0] BASE_RST       = 30'd30000000;
    localparam logic [CNT_W-1:0]  MAX_LEVEL_RST  = 4'd5;

    // register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAIRING_PIN  = 8'd0,
        REG_FAIL_LIMIT   = 8'd1,
        REG_LOCKOUT_BASE = 8'd2,
        REG_MAX_LEVEL    = 8'd3
    } cfg_reg_t;

    // result codes
    typedef enum logic [OUTC_W-1:0] {
        OUT_LOCKED       = 2'd0,
        OUT_PAIRED       = 2'd1,
        OUT_WRONG        = 2'd2,
        OUT_WRONG_LOCKED = 2'd3
    } outcome_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_ADD,
        ST_WRITE
    } seq_state_t;

    // one table row; last_seen of zero marks an empty entry
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  misses;
        logic [CNT_W-1:0]  level;
        logic [TIME_W-1:0] unlock;
        logic [TIME_W-1:0] last_seen;
    } entry_row_t;

    // configuration register set
    typedef struct packed {
        logic [PIN_W-1:0]  pairing_pin;
        logic [CNT_W-1:0]  fail_limit;
        logic [BASE_W-1:0] lockout_base;
        logic [CNT_W-1:0]  max_level;
    } cfg_regs_t;

endpackage

[hw/rtl/per_source_pin_lockout_table_core.sv]
// Top level of the per-source PIN lockout table: config registers, sequencer, entry table.
// Depends on pslt_pkg, pslt_table, pslt_seq and the assertion macro header.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+---------------------------------------------
//   s_       | in        | s_valid / s_ready   | src_addr, now_us, pin_present, entered_pin
//   m_       | out       | m_valid / m_ready   | outcome, slot_used
//   cfg_     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One word at a time: the scan reads one table row per cycle through the table's single
// read port and stops early on a match; the next word is accepted only once the sequencer
// is back in idle after the write-back.
// The result register frees the input side; a stalled m_ready holds only the write-back step.
// Reset is synchronous and clears the table through per-row valid bits, no clearing pass.
// Config writes are taken in every cycle.
`include "per_source_pin_lockout_table_core_macros.svh"

module per_source_pin_lockout_table_core #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pslt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pslt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pslt_pkg::ADDR_W-1:0]     s_src_addr,
    input  logic [pslt_pkg::TIME_W-1:0]     s_now_us,
    input  logic                            s_pin_present,
    input  logic [pslt_pkg::PIN_W-1:0]      s_entered_pin,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pslt_pkg::OUTC_W-1:0]     m_outcome,
    output logic [pslt_pkg::SLOT_W-1:0]     m_slot_used
);
    import pslt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    cfg_regs_t        cfg_reg, cfg_next;
    logic [IDX_W-1:0] tbl_rd_addr;
    entry_row_t       tbl_rd_row;
    logic             tbl_wr_en;
    logic [IDX_W-1:0] tbl_wr_addr;
    entry_row_t       tbl_wr_row;

    // config register writes; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_PAIRING_PIN:  cfg_next.pairing_pin  = cfg_data[PIN_W-1:0];
                REG_FAIL_LIMIT:   cfg_next.fail_limit   = cfg_data[CNT_W-1:0];
                REG_LOCKOUT_BASE: cfg_next.lockout_base = cfg_data[BASE_W-1:0];
                REG_MAX_LEVEL:    cfg_next.max_level    = cfg_data[CNT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pairing_pin  <= PIN_RST;
            cfg_reg.fail_limit   <= FAIL_LIMIT_RST;
            cfg_reg.lockout_base <= BASE_RST;
            cfg_reg.max_level    <= MAX_LEVEL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    // sequencer with shared comparator and result register
    pslt_seq #(
        .DEPTH (TABLE_ENTRIES)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_src_addr    (s_src_addr),
        .s_now_us      (s_now_us),
        .s_pin_present (s_pin_present),
        .s_entered_pin (s_entered_pin),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_outcome     (m_outcome),
        .m_slot_used   (m_slot_used),
        .tbl_rd_addr   (tbl_rd_addr),
        .tbl_rd_row    (tbl_rd_row),
        .tbl_wr_en     (tbl_wr_en),
        .tbl_wr_addr   (tbl_wr_addr),
        .tbl_wr_row    (tbl_wr_row)
    );

    // per-source entry table
    pslt_table #(
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (tbl_rd_addr),
        .rd_row  (tbl_rd_row),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_row  (tbl_wr_row)
    );

    // an accepted word keeps the input closed while it is scanned
    `PSLT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a new result only comes out of the busy write-back step
    `PSLT_ASSERT_SAME(a_result_after_busy, aclk, aresetn, $rose(m_valid), $past(!s_ready))
    // the reported slot lies inside the table
    `PSLT_ASSERT_SAME(a_slot_in_range, aclk, aresetn, m_valid, 32'(m_slot_used) < TABLE_ENTRIES)

endmodule

[hw/rtl/pslt_cmp.sv]
// Shared 48-bit magnitude comparator, time-multiplexed by the sequencer.
// Depends on pslt_pkg.
module pslt_cmp (
    input  logic [pslt_pkg::TIME_W-1:0] a,
    input  logic [pslt_pkg::TIME_W-1:0] b,
    output logic                        lt
);
    import pslt_pkg::*;

    // unsigned a < b
    assign lt = (a < b);

endmodule

[hw/rtl/pslt_table.sv]
// Entry table: one row per source, one write and one registered read per cycle.
// Per-row valid flops give reset-to-zero rows without a clearing pass. Depends on pslt_pkg.
module pslt_table #(
    parameter int  DEPTH = 8,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [IDX_W-1:0]     rd_addr,
    output pslt_pkg::entry_row_t rd_row,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  pslt_pkg::entry_row_t wr_row
);
    import pslt_pkg::*;

    entry_row_t             row_mem_reg [DEPTH];
    logic       [DEPTH-1:0] row_vld_reg;
    entry_row_t             rd_row_reg;
    logic                   rd_vld_reg;

    // row storage and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem_reg[wr_addr] <= wr_row;
        end
        rd_row_reg <= row_mem_reg[rd_addr];
    end

    // valid bits, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= row_vld_reg[rd_addr];
        end
    end

    // a never-written row reads as all zero
    assign rd_row = rd_vld_reg ? rd_row_reg : '0;

endmodule

[hw/rtl/pslt_seq.sv]
// Sequencer: scans the table one row per cycle, then evaluates, adds and writes back.
// Holds the result word register. Depends on pslt_pkg, pslt_cmp.
module pslt_seq #(
    parameter int  DEPTH = 8,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pslt_pkg::cfg_regs_t           cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pslt_pkg::ADDR_W-1:0]   s_src_addr,
    input  logic [pslt_pkg::TIME_W-1:0]   s_now_us,
    input  logic                          s_pin_present,
    input  logic [pslt_pkg::PIN_W-1:0]    s_entered_pin,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pslt_pkg::OUTC_W-1:0]   m_outcome,
    output logic [pslt_pkg::SLOT_W-1:0]   m_slot_used,
    output logic [IDX_W-1:0]              tbl_rd_addr,
    input  pslt_pkg::entry_row_t          tbl_rd_row,
    output logic                          tbl_wr_en,
    output logic [IDX_W-1:0]              tbl_wr_addr,
    output pslt_pkg::entry_row_t          tbl_wr_row
);
    import pslt_pkg::*;

    localparam logic [IDX_W:0]   ISSUE_END = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

    seq_state_t state_reg, state_next;

    // captured request word
    logic [ADDR_W-1:0] ip_reg, ip_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic              present_reg, present_next;
    logic [PIN_W-1:0]  pin_reg, pin_next;

    // scan pipeline
    logic [IDX_W:0]    issue_reg, issue_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [TIME_W-1:0] best_ls_reg, best_ls_next;
    logic [IDX_W-1:0]  victim_reg, victim_next;

    // chosen entry and evaluation results
    entry_row_t        cur_row_reg, cur_row_next;
    logic [IDX_W-1:0]  cur_idx_reg, cur_idx_next;
    logic              locked_reg, locked_next;
    logic              pin_ok_reg, pin_ok_next;
    logic              reach_reg, reach_next;
    logic              lvl_below_reg, lvl_below_next;
    logic [CNT_W:0]    misses1_reg, misses1_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [TIME_W-1:0] until_reg, until_next;

    // result word
    logic              m_valid_reg, m_valid_next;
    outcome_t          m_outcome_reg, m_outcome_next;
    logic [SLOT_W-1:0] m_slot_reg, m_slot_next;

    // shared comparator operands
    logic [TIME_W-1:0] cmp_a, cmp_b;
    logic              cmp_lt;

    logic [TIME_W:0]   sum;
    logic [CNT_W-1:0]  shift;
    logic              hit;
    logic              take;

    pslt_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt)
    );

    // comparator operand select per state
    always_comb begin
        unique case (state_reg)
            ST_SCAN: begin
                cmp_a = tbl_rd_row.last_seen;
                cmp_b = best_ls_reg;
            end
            ST_EVAL: begin
                cmp_a = now_reg;
                cmp_b = cur_row_reg.unlock;
            end
            default: begin
                cmp_a = now_reg;
                cmp_b = until_reg;
            end
        endcase
    end

    // scan-time match and victim pick (smallest last_seen wins, a tie keeps the lower row)
    assign hit  = pend_vld_reg && (tbl_rd_row.last_seen != '0) && (tbl_rd_row.addr == ip_reg);
    assign take = (pend_idx_reg == '0) || cmp_lt;

    // lock length and saturating unlock time
    assign shift = (cur_row_reg.level < cfg.max_level) ? cur_row_reg.level : cfg.max_level;
    assign sum   = {1'b0, now_reg} + (TIME_W + 1)'(len_reg);

    // next state and datapath
    always_comb begin
        state_next     = state_reg;
        ip_next        = ip_reg;
        now_next       = now_reg;
        present_next   = present_reg;
        pin_next       = pin_reg;
        issue_next     = issue_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        best_ls_next   = best_ls_reg;
        victim_next    = victim_reg;
        cur_row_next   = cur_row_reg;
        cur_idx_next   = cur_idx_reg;
        locked_next    = locked_reg;
        pin_ok_next    = pin_ok_reg;
        reach_next     = reach_reg;
        lvl_below_next = lvl_below_reg;
        misses1_next   = misses1_reg;
        len_next       = len_reg;
        until_next     = until_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_outcome_next = m_outcome_reg;
        m_slot_next    = m_slot_reg;
        tbl_rd_addr    = '0;
        tbl_wr_en      = 1'b0;
        tbl_wr_addr    = cur_idx_reg;
        tbl_wr_row     = cur_row_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ip_next       = s_src_addr;
                    now_next      = s_now_us;
                    present_next  = s_pin_present;
                    pin_next      = s_entered_pin;
                    issue_next    = '0;
                    pend_vld_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // issue the next row read
                if (issue_reg < ISSUE_END) begin
                    tbl_rd_addr   = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + 1'b1;
                    pend_vld_next = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                end else begin
                    pend_vld_next = 1'b0;
                end
                // check the row that came back
                if (pend_vld_reg) begin
                    if (take) begin
                        best_ls_next = tbl_rd_row.last_seen;
                        victim_next  = pend_idx_reg;
                    end
                    if (hit) begin
                        cur_row_next = tbl_rd_row;
                        cur_idx_next = pend_idx_reg;
                        state_next   = ST_EVAL;
                    end else if (pend_idx_reg == LAST_IDX) begin
                        cur_idx_next      = take ? pend_idx_reg : victim_reg;
                        cur_row_next      = '0;
                        cur_row_next.addr = ip_reg;
                        state_next        = ST_EVAL;
                    end
                end
            end

            ST_EVAL: begin
                locked_next    = cmp_lt;
                pin_ok_next    = present_reg && (pin_reg == cfg.pairing_pin);
                misses1_next   = {1'b0, cur_row_reg.misses} + 1'b1;
                reach_next     = (({1'b0, cur_row_reg.misses} + 1'b1) >= {1'b0, cfg.fail_limit});
                lvl_below_next = (cur_row_reg.level < cfg.max_level);
                len_next       = LEN_W'(cfg.lockout_base) << shift;
                state_next     = ST_ADD;
            end

            ST_ADD: begin
                until_next = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                state_next = ST_WRITE;
            end

            ST_WRITE: begin
                // write back once the result register is free
                if (!m_valid_reg || m_ready) begin
                    tbl_wr_en            = 1'b1;
                    tbl_wr_row.last_seen = now_reg;
                    if (locked_reg) begin
                        m_outcome_next = OUT_LOCKED;
                    end else if (pin_ok_reg) begin
                        tbl_wr_row.misses = '0;
                        tbl_wr_row.level  = '0;
                        tbl_wr_row.unlock = '0;
                        m_outcome_next    = OUT_PAIRED;
                    end else if (reach_reg) begin
                        tbl_wr_row.unlock = until_reg;
                        tbl_wr_row.misses = '0;
                        if (lvl_below_reg) begin
                            tbl_wr_row.level = cur_row_reg.level + 1'b1;
                        end
                        m_outcome_next = cmp_lt ? OUT_WRONG_LOCKED : OUT_WRONG;
                    end else begin
                        tbl_wr_row.misses = misses1_reg[CNT_W] ? MISS_MAX
                                                               : misses1_reg[CNT_W-1:0];
                        m_outcome_next    = OUT_WRONG;
                    end
                    m_slot_next  = SLOT_W'(cur_idx_reg);
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            issue_reg    <= '0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            issue_reg    <= issue_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        ip_reg        <= ip_next;
        now_reg       <= now_next;
        present_reg   <= present_next;
        pin_reg       <= pin_next;
        pend_idx_reg  <= pend_idx_next;
        best_ls_reg   <= best_ls_next;
        victim_reg    <= victim_next;
        cur_row_reg   <= cur_row_next;
        cur_idx_reg   <= cur_idx_next;
        locked_reg    <= locked_next;
        pin_ok_reg    <= pin_ok_next;
        reach_reg     <= reach_next;
        lvl_below_reg <= lvl_below_next;
        misses1_reg   <= misses1_next;
        len_reg       <= len_next;
        until_reg     <= until_next;
        m_outcome_reg <= m_outcome_next;
        m_slot_reg    <= m_slot_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_outcome   = m_outcome_reg;
    assign m_slot_used = m_slot_reg;

endmodule
